### hw/rtl/totalizer_report_filter_top_assert.svh
// Assertion macros for the totalizer report filter.
// The clock and reset in scope must be named clk and rst_n.
`ifndef TOTALIZER_REPORT_FILTER_TOP_ASSERT_SVH
`define TOTALIZER_REPORT_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge out of reset.
`define TRF_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that a trigger is followed by a condition in the next cycle.
`define TRF_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TRF_ASSERT(lbl, cond, msg)
`define TRF_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hw/rtl/trf_pkg.sv
// Shared constants for the totalizer report filter.
// No dependencies; used by the channel interfaces and the top level.
package trf_pkg;

    localparam int CHANNELS   = 2;
    localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHANNEL_W  = 1;
    localparam int VALUE_W    = 48;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_STABLE_COUNT = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_MIN_INTERVAL = REG_IDX_W'(1);

    localparam logic [COUNT_W-1:0] STABLE_COUNT_RESET = COUNT_W'(10);
    localparam logic [TIME_W-1:0]  MIN_INTERVAL_RESET = TIME_W'(300000);
    localparam logic [COUNT_W-1:0] COUNT_MAX          = {COUNT_W{1'b1}};

endpackage

### hw/rtl/trf_frame_if.sv
// Input channel carrying one meter frame request.
// Depends on trf_pkg for field widths.
interface trf_frame_if;
    logic                             valid;
    logic                             ready;
    logic [trf_pkg::CHANNEL_W-1:0]    channel;
    logic                             totalizer_mode;
    logic [trf_pkg::VALUE_W-1:0]      reading_value;
    logic [trf_pkg::TIME_W-1:0]       time_ms;

    modport source (output valid, channel, totalizer_mode, reading_value, time_ms,
                    input ready);
    modport sink   (input valid, channel, totalizer_mode, reading_value, time_ms,
                    output ready);
endinterface

### hw/rtl/trf_report_if.sv
// Output channel carrying one report request per frame.
// Depends on trf_pkg for field widths.
interface trf_report_if;
    logic                        valid;
    logic                        ready;
    logic                        report_valid;
    logic [trf_pkg::VALUE_W-1:0] report_value;

    modport source (output valid, report_valid, report_value, input ready);
    modport sink   (input valid, report_valid, report_value, output ready);
endinterface

### hw/rtl/totalizer_report_filter_top.sv
// Totalizer report filter: per-channel report decision for meter frames.
// A frame passes through the input register and then the result register to the output.
// Throughput: one frame per cycle while the output is not stalled; channel state is read and
// written in the same cycle that a frame moves from the input register to the result register.
// Reset: clears all channel state and loads stable_count 10, min_interval_ms 300000.
// Depends on trf_pkg, trf_frame_if, trf_report_if and the assertion header.
`include "totalizer_report_filter_top_assert.svh"

module totalizer_report_filter_top (
    input  logic                             clk,
    input  logic                             rst_n,
    trf_frame_if.sink                        in_frame,
    trf_report_if.source                     out_report,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [trf_pkg::PADDR_W-1:0]      paddr,
    input  logic [trf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [trf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    // ------------------------------------------------------------------
    // Configuration registers (APB, zero wait states)
    // ------------------------------------------------------------------
    logic [trf_pkg::COUNT_W-1:0]   stable_count_reg;
    logic [trf_pkg::TIME_W-1:0]    min_interval_reg;
    logic                          cfg_write;
    logic [trf_pkg::REG_IDX_W-1:0] reg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    // Decode on the word index; byte offset bits are ignored.
    assign reg_idx   = paddr[trf_pkg::PADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_count_reg <= trf_pkg::STABLE_COUNT_RESET;
            min_interval_reg <= trf_pkg::MIN_INTERVAL_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_idx == trf_pkg::REG_STABLE_COUNT)
            begin
                stable_count_reg <= pwdata;
            end
            if (reg_idx == trf_pkg::REG_MIN_INTERVAL)
            begin
                min_interval_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            trf_pkg::REG_STABLE_COUNT: prdata = stable_count_reg;
            trf_pkg::REG_MIN_INTERVAL: prdata = min_interval_reg;
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. A frame in the
    // input register advances whenever the result register is empty or is
    // being drained this cycle, so a new frame can enter every cycle while the sink is ready.
    // ------------------------------------------------------------------
    logic                             s1_valid_reg;
    logic [trf_pkg::CHANNEL_W-1:0]    s1_channel_reg;
    logic                             s1_mode_reg;
    logic [trf_pkg::VALUE_W-1:0]      s1_reading_reg;
    logic [trf_pkg::TIME_W-1:0]       s1_time_reg;

    logic                             out_valid_reg;
    logic                             out_report_valid_reg;
    logic [trf_pkg::VALUE_W-1:0]      out_report_value_reg;

    logic out_free;
    logic s1_adv;
    logic in_acc;

    assign out_free       = !out_valid_reg || out_report.ready;
    assign s1_adv         = s1_valid_reg && out_free;
    assign in_frame.ready = !s1_valid_reg || out_free;
    assign in_acc         = in_frame.valid && in_frame.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_report.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the frame payload on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_channel_reg <= in_frame.channel;
            s1_mode_reg    <= in_frame.totalizer_mode;
            s1_reading_reg <= in_frame.reading_value;
            s1_time_reg    <= in_frame.time_ms;
        end
    end

    // ------------------------------------------------------------------
    // Per-channel state
    // ------------------------------------------------------------------
    logic [trf_pkg::VALUE_W-1:0] last_reported_value_reg [trf_pkg::CHANNELS];
    logic [trf_pkg::TIME_W-1:0]  last_reported_time_reg  [trf_pkg::CHANNELS];
    logic [trf_pkg::VALUE_W-1:0] last_seen_value_reg     [trf_pkg::CHANNELS];
    logic [trf_pkg::COUNT_W-1:0] repeat_count_reg        [trf_pkg::CHANNELS];
    logic                        was_in_mode_reg         [trf_pkg::CHANNELS];

    logic [trf_pkg::CH_IDX_W-1:0] cur_idx;
    logic                         in_range;
    logic [trf_pkg::VALUE_W-1:0]  cur_lrv;
    logic [trf_pkg::TIME_W-1:0]   cur_lrt;
    logic [trf_pkg::VALUE_W-1:0]  cur_seen;
    logic [trf_pkg::COUNT_W-1:0]  cur_rc;
    logic                         cur_was;

    assign cur_idx  = trf_pkg::CH_IDX_W'(s1_channel_reg);
    // A channel number beyond the configured count touches no state.
    assign in_range = 32'(s1_channel_reg) < 32'(trf_pkg::CHANNELS);
    assign cur_lrv  = last_reported_value_reg[cur_idx];
    assign cur_lrt  = last_reported_time_reg[cur_idx];
    assign cur_seen = last_seen_value_reg[cur_idx];
    assign cur_rc   = repeat_count_reg[cur_idx];
    assign cur_was  = was_in_mode_reg[cur_idx];

    // ------------------------------------------------------------------
    // Report decision
    // ------------------------------------------------------------------
    logic                        mode_entry;
    logic [trf_pkg::TIME_W-1:0]  elapsed;
    logic                        stable;
    logic                        gap_met;
    logic                        changed;
    logic                        report;
    logic [trf_pkg::VALUE_W-1:0] report_value;
    logic [trf_pkg::VALUE_W-1:0] lrv_next;
    logic [trf_pkg::TIME_W-1:0]  lrt_next;
    logic [trf_pkg::VALUE_W-1:0] seen_next;
    logic [trf_pkg::COUNT_W-1:0] rc_next;
    logic                        state_write;

    assign mode_entry  = s1_mode_reg && !cur_was;
    // Elapsed time wraps modulo 2^32.
    assign elapsed     = s1_time_reg - cur_lrt;
    assign gap_met     = elapsed >= min_interval_reg;
    assign changed     = s1_reading_reg != cur_lrv;
    assign state_write = s1_adv && in_range;

    always_comb
    begin
        report       = 1'b0;
        report_value = '0;
        lrv_next     = cur_lrv;
        lrt_next     = cur_lrt;
        seen_next    = cur_seen;
        rc_next      = cur_rc;
        stable       = 1'b0;

        if (mode_entry)
        begin
            // Entering the mode: report the reading at once.
            seen_next    = s1_reading_reg;
            rc_next      = '0;
            lrv_next     = s1_reading_reg;
            lrt_next     = s1_time_reg;
            report       = 1'b1;
            report_value = s1_reading_reg;
        end
        else if (s1_mode_reg)
        begin
            // Staying in the mode: track repeats, saturating at all ones.
            if (s1_reading_reg != cur_seen)
            begin
                seen_next = s1_reading_reg;
                rc_next   = '0;
            end
            else if (cur_rc != trf_pkg::COUNT_MAX)
            begin
                rc_next = cur_rc + trf_pkg::COUNT_W'(1);
            end

            // Judge stability on the updated repeat count.
            stable = rc_next >= stable_count_reg;

            if (stable && gap_met && changed)
            begin
                lrv_next     = s1_reading_reg;
                lrt_next     = s1_time_reg;
                report       = 1'b1;
                report_value = s1_reading_reg;
            end
        end
        else if (cur_was)
        begin
            // Leaving the mode: flush the last reading if never reported.
            if (cur_seen != cur_lrv)
            begin
                lrv_next     = cur_seen;
                lrt_next     = s1_time_reg;
                report       = 1'b1;
                report_value = cur_seen;
            end
        end

        if (!in_range)
        begin
            report       = 1'b0;
            report_value = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < trf_pkg::CHANNELS; i++)
            begin
                last_reported_value_reg[i] <= '0;
                last_reported_time_reg[i]  <= '0;
                last_seen_value_reg[i]     <= '0;
                repeat_count_reg[i]        <= '0;
                was_in_mode_reg[i]         <= 1'b0;
            end
        end
        else if (state_write)
        begin
            last_reported_value_reg[cur_idx] <= lrv_next;
            last_reported_time_reg[cur_idx]  <= lrt_next;
            last_seen_value_reg[cur_idx]     <= seen_next;
            repeat_count_reg[cur_idx]        <= rc_next;
            was_in_mode_reg[cur_idx]         <= s1_mode_reg;
        end
    end

    // Result register: hold until the sink takes it.
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_report_valid_reg <= report;
            out_report_value_reg <= report_value;
        end
    end

    assign out_report.valid        = out_valid_reg;
    assign out_report.report_valid = out_report_valid_reg;
    assign out_report.report_value = out_report_value_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TRF_ASSERT(a_zero_when_quiet,
        !(out_valid_reg && !out_report_valid_reg && (out_report_value_reg != '0)),
        "report value not zero without a report")
    `TRF_ASSERT_NEXT(a_entry_reports, s1_adv && in_range && mode_entry,
        out_valid_reg && out_report_valid_reg, "mode entry did not report")
    `TRF_ASSERT_NEXT(a_report_recorded, state_write && report,
        last_reported_value_reg[$past(cur_idx)] == out_report_value_reg,
        "last reported value differs from the report")
    `TRF_ASSERT_NEXT(a_count_saturates,
        state_write && s1_mode_reg && cur_was && (cur_rc == trf_pkg::COUNT_MAX)
            && (s1_reading_reg == cur_seen),
        repeat_count_reg[$past(cur_idx)] == trf_pkg::COUNT_MAX,
        "repeat count wrapped")

endmodule

### tb/totalizer_report_filter_top_tb.sv
// Testbench for totalizer_report_filter_top: directed and random meter frames, checked
// against a cycle-free predictor of the per-channel report decision.
// Depends on trf_pkg, trf_frame_if, trf_report_if and the top-level RTL.
module totalizer_report_filter_top_tb;

    typedef struct packed {
        logic [trf_pkg::CHANNEL_W-1:0] channel;
        logic                          totalizer_mode;
        logic [trf_pkg::VALUE_W-1:0]   reading_value;
        logic [trf_pkg::TIME_W-1:0]    time_ms;
    } frame_t;

    typedef struct packed {
        logic                        report_valid;
        logic [trf_pkg::VALUE_W-1:0] report_value;
    } report_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [trf_pkg::PADDR_W-1:0]    paddr;
    logic [trf_pkg::CFG_DATA_W-1:0] pwdata;
    logic [trf_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    trf_frame_if  frame_bus ();
    trf_report_if report_bus ();

    totalizer_report_filter_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_frame   (frame_bus),
        .out_report (report_bus),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Predictor copy of the configuration and of the per-channel state.
    logic [trf_pkg::COUNT_W-1:0] cfg_stable_count;
    logic [trf_pkg::TIME_W-1:0]  cfg_min_interval;
    logic [trf_pkg::VALUE_W-1:0] ch_reported_value [trf_pkg::CHANNELS];
    logic [trf_pkg::TIME_W-1:0]  ch_reported_time  [trf_pkg::CHANNELS];
    logic [trf_pkg::VALUE_W-1:0] ch_seen_value     [trf_pkg::CHANNELS];
    logic [trf_pkg::COUNT_W-1:0] ch_repeats        [trf_pkg::CHANNELS];
    logic                        ch_in_mode        [trf_pkg::CHANNELS];

    report_t pending_reports[$];
    report_t oldest_report;
    int      fail_count;
    bit      idle_on;

    // Clock: period 10.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop in case a handshake never completes.
    initial
    begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [trf_pkg::VALUE_W-1:0] random_reading();
        return trf_pkg::VALUE_W'({$urandom(), $urandom()});
    endfunction

    // Work out the report that one accepted frame causes, and advance the channel state.
    function automatic report_t filter_frame(frame_t f);
        report_t                    r;
        int                         c;
        logic [trf_pkg::TIME_W-1:0] elapsed;
        r = '0;
        c = int'(f.channel);
        if (c < trf_pkg::CHANNELS)
        begin
            if (f.totalizer_mode && !ch_in_mode[c])
            begin
                // Mode entry: report at once and restart the repeat run.
                ch_seen_value[c]     = f.reading_value;
                ch_repeats[c]        = '0;
                ch_reported_value[c] = f.reading_value;
                ch_reported_time[c]  = f.time_ms;
                r = '{1'b1, f.reading_value};
            end
            else if (f.totalizer_mode)
            begin
                if (f.reading_value != ch_seen_value[c])
                begin
                    ch_seen_value[c] = f.reading_value;
                    ch_repeats[c]    = '0;
                end
                else if (ch_repeats[c] != trf_pkg::COUNT_MAX)
                    ch_repeats[c] = ch_repeats[c] + trf_pkg::COUNT_W'(1);
                elapsed = f.time_ms - ch_reported_time[c];
                if (ch_repeats[c] >= cfg_stable_count && elapsed >= cfg_min_interval &&
                    f.reading_value != ch_reported_value[c])
                begin
                    ch_reported_value[c] = f.reading_value;
                    ch_reported_time[c]  = f.time_ms;
                    r = '{1'b1, f.reading_value};
                end
            end
            else if (ch_in_mode[c] && ch_seen_value[c] != ch_reported_value[c])
            begin
                // Mode exit: flush a reading that never made it out.
                ch_reported_value[c] = ch_seen_value[c];
                ch_reported_time[c]  = f.time_ms;
                r = '{1'b1, ch_seen_value[c]};
            end
            ch_in_mode[c] = f.totalizer_mode;
        end
        return r;
    endfunction

    task automatic note_failure(string what, report_t want, report_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected valid %0b value %h, got valid %0b value %h",
                     $realtime, what, want.report_valid, want.report_value,
                     got.report_valid, got.report_value);
    endtask

    // Send one frame request: hold off for a random gap, then hold valid until accepted.
    task automatic send_frame(frame_t f);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            frame_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_bus.valid          <= 1'b1;
        frame_bus.channel        <= f.channel;
        frame_bus.totalizer_mode <= f.totalizer_mode;
        frame_bus.reading_value  <= f.reading_value;
        frame_bus.time_ms        <= f.time_ms;
        do
            @(posedge clk);
        while (!frame_bus.ready);
        pending_reports.push_back(filter_frame(f));
    endtask

    // Drop valid and wait until every report is back plus the pipeline depth.
    task automatic drain_reports();
        frame_bus.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [trf_pkg::REG_IDX_W-1:0] idx,
                                  logic [trf_pkg::CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == trf_pkg::REG_STABLE_COUNT)
            cfg_stable_count = data;
        else if (idx == trf_pkg::REG_MIN_INTERVAL)
            cfg_min_interval = data;
        @(posedge clk);
    endtask

    // Reconfigure only once the block has gone quiet.
    task automatic set_thresholds(logic [trf_pkg::COUNT_W-1:0] stable,
                                  logic [trf_pkg::TIME_W-1:0] interval);
        drain_reports();
        write_register(trf_pkg::REG_STABLE_COUNT, stable);
        write_register(trf_pkg::REG_MIN_INTERVAL, interval);
    endtask

    // Entry, exit, exit with nothing new, and frames outside the mode, at reset settings.
    task automatic test_entry_and_exit();
        send_frame('{1'b0, 1'b0, 48'h1234, 32'd5});
        send_frame('{1'b0, 1'b1, '1, '1});
        send_frame('{1'b1, 1'b1, '0, '0});
        send_frame('{1'b0, 1'b1, 48'd5, 32'd1});
        send_frame('{1'b0, 1'b0, 48'd9, 32'd2});
        send_frame('{1'b0, 1'b0, 48'd9, 32'd3});
        send_frame('{1'b1, 1'b0, 48'd7, 32'd4});
    endtask

    // Stable reading across the 32-bit time wrap, short of and past the interval.
    task automatic test_time_wrap();
        set_thresholds(32'd1, 32'd100);
        send_frame('{1'b0, 1'b1, 48'hAAAA_5555_0001, 32'hFFFF_FFC0});
        send_frame('{1'b0, 1'b1, 48'h8000_0000_0000, 32'hFFFF_FFF0});
        send_frame('{1'b0, 1'b1, 48'h8000_0000_0000, 32'h0000_0020});
        send_frame('{1'b0, 1'b1, 48'h8000_0000_0000, 32'h0000_0030});
        send_frame('{1'b0, 1'b1, 48'h8000_0000_0000, 32'h0000_0100});
        send_frame('{1'b0, 1'b0, 48'h0, 32'h0000_0200});
    endtask

    // Extreme thresholds: never stable, then every changed reading reports at once.
    task automatic test_threshold_extremes();
        set_thresholds('1, '1);
        send_frame('{1'b1, 1'b1, 48'd100, 32'd10});
        send_frame('{1'b1, 1'b1, 48'd100, 32'd11});
        send_frame('{1'b1, 1'b1, 48'd200, '0});
        send_frame('{1'b1, 1'b0, 48'd300, 32'd12});
        set_thresholds('0, '0);
        send_frame('{1'b1, 1'b1, 48'd1, 32'd20});
        send_frame('{1'b1, 1'b1, 48'd2, 32'd20});
        send_frame('{1'b1, 1'b1, 48'd2, 32'd20});
        send_frame('{1'b1, 1'b1, 48'd1, 32'd19});
        send_frame('{1'b1, 1'b0, 48'd3, 32'd21});
    endtask

    // Random sessions per channel: mostly repeated readings with slowly advancing time,
    // occasional mode flips, time jumps and fully random noise frames.
    task automatic test_random_traffic();
        frame_t                      f;
        int unsigned                 phase;
        int unsigned                 n;
        logic [trf_pkg::TIME_W-1:0]  clock_ms;
        logic                        in_mode [trf_pkg::CHANNELS];
        logic [trf_pkg::VALUE_W-1:0] meter   [trf_pkg::CHANNELS];
        int unsigned                 ch;
        clock_ms = $urandom();
        for (int i = 0; i < trf_pkg::CHANNELS; i++)
        begin
            in_mode[i] = 1'b0;
            meter[i]   = random_reading();
        end
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_thresholds('0, '0);
                1: set_thresholds('1, '1);
                2: set_thresholds(trf_pkg::STABLE_COUNT_RESET, trf_pkg::MIN_INTERVAL_RESET);
                default: set_thresholds($urandom_range(0, 6), $urandom_range(0, 150));
            endcase
            for (n = 0; n < 210; n++)
            begin
                // Leave some stretches with no gaps on either side.
                if (n % 50 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) == 0)
                    f = '{trf_pkg::CHANNEL_W'($urandom()), 1'($urandom()),
                          random_reading(), $urandom()};
                else
                begin
                    ch = $urandom_range(0, trf_pkg::CHANNELS - 1);
                    if ($urandom_range(0, 11) == 0)
                        in_mode[ch] = !in_mode[ch];
                    if ($urandom_range(0, 3) == 0)
                        meter[ch] = ($urandom_range(0, 7) == 0) ? random_reading() :
                                    meter[ch] + trf_pkg::VALUE_W'($urandom_range(1, 500));
                    if ($urandom_range(0, 63) == 0)
                        clock_ms = $urandom();
                    else
                        clock_ms = clock_ms + trf_pkg::TIME_W'($urandom_range(0, 40));
                    f = '{trf_pkg::CHANNEL_W'(ch), in_mode[ch], meter[ch], clock_ms};
                end
                send_frame(f);
            end
        end
    endtask

    // Report side: stall a random number of cycles before each request.
    initial
    begin
        int unsigned stall;
        report_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall > 0)
            begin
                report_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            report_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!report_bus.valid);
        end
    end

    // Check each accepted report against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && report_bus.valid && report_bus.ready)
        begin
            if (pending_reports.size() == 0)
                note_failure("unexpected report", '0,
                             '{report_bus.report_valid, report_bus.report_value});
            else
            begin
                oldest_report = pending_reports.pop_front();
                if (report_bus.report_valid !== oldest_report.report_valid ||
                    report_bus.report_value !== oldest_report.report_value)
                    note_failure("report mismatch", oldest_report,
                                 '{report_bus.report_valid, report_bus.report_value});
            end
        end
    end

    initial
    begin
        report_t leftover;
        fail_count       = 0;
        idle_on          = 1'b1;
        cfg_stable_count = trf_pkg::STABLE_COUNT_RESET;
        cfg_min_interval = trf_pkg::MIN_INTERVAL_RESET;
        for (int i = 0; i < trf_pkg::CHANNELS; i++)
        begin
            ch_reported_value[i] = '0;
            ch_reported_time[i]  = '0;
            ch_seen_value[i]     = '0;
            ch_repeats[i]        = '0;
            ch_in_mode[i]        = 1'b0;
        end
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = '0;
        frame_bus.valid          = 1'b0;
        frame_bus.channel        = '0;
        frame_bus.totalizer_mode = 1'b0;
        frame_bus.reading_value  = '0;
        frame_bus.time_ms        = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_entry_and_exit();
        test_time_wrap();
        test_threshold_extremes();
        test_random_traffic();

        // Wait out the last reports and the pipeline depth.
        drain_reports();
        repeat (8) @(posedge clk);
        while (pending_reports.size() != 0)
        begin
            leftover = pending_reports.pop_front();
            note_failure("missing report", leftover, '0);
        end
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
